/* design/assert_macros.svh */
// assertion macros used by the deque top-level design file
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define DEQ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("deque assertion failed");
// expression must never be true outside reset
`define DEQ_ASSERT_NEVER(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
		else $error("deque assertion failed");
`else
`define DEQ_ASSERT(lbl, clk, rst_n, prop)
`define DEQ_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

/* design/deq_pkg.sv */
// types, constants and helper functions for the double-ended queue
// no dependencies
package deq_pkg;

	localparam int CAPACITY       = 1024;
	localparam int WORD_BITS      = 32;
	localparam int PTR_BITS       = $clog2(CAPACITY);
	localparam int CNT_BITS       = $clog2(CAPACITY + 1);
	localparam int KIND_BITS      = 3;
	localparam int IN_WORD_BITS   = 32;
	localparam int OUT_WORD_BITS  = 32;
	localparam int COUNT_OUT_BITS = 11;

	typedef logic [PTR_BITS-1:0]  ptr_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;
	typedef logic [WORD_BITS-1:0] word_t;

	localparam ptr_t LAST_SLOT  = PTR_BITS'(CAPACITY - 1);
	localparam cnt_t FULL_COUNT = CNT_BITS'(CAPACITY);
	localparam logic [COUNT_OUT_BITS-1:0] FULL_COUNT_OUT = COUNT_OUT_BITS'(CAPACITY);

	typedef enum logic [KIND_BITS-1:0] {
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_QUERY
	} op_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_EMPTY,
		ST_FULL
	} status_t;

	// per-item update handed from the pointer logic to the result stage
	typedef struct packed {
		status_t status;
		logic    take_front;
		logic    take_back;
		cnt_t    count;
		logic    hit_front;
		logic    hit_back;
		word_t   word;
	} deq_upd_t;

	function automatic ptr_t next_slot(input ptr_t i);
		return (i == LAST_SLOT) ? '0 : i + ptr_t'(1);
	endfunction

	function automatic ptr_t prev_slot(input ptr_t i);
		return (i == '0) ? LAST_SLOT : i - ptr_t'(1);
	endfunction

	// input word sign-extended, then cut to the stored width
	function automatic word_t word_from_in(input logic signed [IN_WORD_BITS-1:0] v);
		logic signed [63:0] ext;
		ext = 64'(v);
		return ext[WORD_BITS-1:0];
	endfunction

	// stored word sign-extended, then cut to the result width
	function automatic logic signed [OUT_WORD_BITS-1:0] word_to_out(input word_t w);
		logic signed [63:0] ext;
		ext = 64'(signed'(w));
		return ext[OUT_WORD_BITS-1:0];
	endfunction

endpackage

/* design/deq_in_if.sv */
// request channel of the deque: operation kind and push word
// depends on deq_pkg
interface deq_in_if;
	import deq_pkg::*;

	logic                           valid;
	logic                           ready;
	logic [KIND_BITS-1:0]           kind;
	logic signed [IN_WORD_BITS-1:0] push_value;

	modport source (output valid, kind, push_value, input ready);
	modport sink (input valid, kind, push_value, output ready);
endinterface

/* design/deq_out_if.sv */
// response channel of the deque: status, popped word, count and end words
// depends on deq_pkg
interface deq_out_if;
	import deq_pkg::*;

	logic                            valid;
	logic                            ready;
	status_t                         status;
	logic signed [OUT_WORD_BITS-1:0] popped_value;
	logic [COUNT_OUT_BITS-1:0]       entry_count;
	logic                            is_empty;
	logic signed [OUT_WORD_BITS-1:0] front_value;
	logic signed [OUT_WORD_BITS-1:0] back_value;

	modport source (output valid, status, popped_value, entry_count, is_empty,
		front_value, back_value, input ready);
	modport sink (input valid, status, popped_value, entry_count, is_empty,
		front_value, back_value, output ready);
endinterface

/* design/deq_ram.sv */
// generic RAM: one write port, two read ports with registered read data
// no dependencies
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read ports, held while idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a_q <= mem_q[raddr_a];
			rdata_b_q <= mem_q[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;
endmodule

/* design/deq_ctrl.sv */
// head, tail and count registers of the ring; decodes each operation
// depends on deq_pkg; drives the ring RAM and the result stage
module deq_ctrl (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    accept,
	input  logic [deq_pkg::KIND_BITS-1:0]           kind,
	input  logic signed [deq_pkg::IN_WORD_BITS-1:0] push_value,
	output logic                                    ram_we,
	output deq_pkg::ptr_t                           ram_waddr,
	output deq_pkg::word_t                          ram_wdata,
	output deq_pkg::ptr_t                           ram_raddr_front,
	output deq_pkg::ptr_t                           ram_raddr_back,
	output deq_pkg::deq_upd_t                       upd
);
	import deq_pkg::*;

	ptr_t  head_q;
	ptr_t  tail_q;
	cnt_t  count_q;
	ptr_t  head_n;
	ptr_t  tail_n;
	cnt_t  count_n;
	ptr_t  waddr;
	logic  do_write;
	logic  is_full;
	logic  is_empty;
	word_t word;

	assign is_full  = (count_q == FULL_COUNT);
	assign is_empty = (count_q == '0);
	assign word     = word_from_in(push_value);

	// operation decode and next pointer values
	always_comb begin
		head_n         = head_q;
		tail_n         = tail_q;
		count_n        = count_q;
		waddr          = tail_q;
		do_write       = 1'b0;
		upd.status     = ST_OK;
		upd.take_front = 1'b0;
		upd.take_back  = 1'b0;
		case (op_t'(kind))
			OP_PUSH_FRONT: begin
				if (is_full) begin
					upd.status = ST_FULL;
				end else begin
					head_n   = prev_slot(head_q);
					waddr    = head_n;
					do_write = 1'b1;
					count_n  = count_q + cnt_t'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (is_full) begin
					upd.status = ST_FULL;
				end else begin
					waddr    = tail_q;
					tail_n   = next_slot(tail_q);
					do_write = 1'b1;
					count_n  = count_q + cnt_t'(1);
				end
			end
			OP_POP_FRONT: begin
				if (is_empty) begin
					upd.status = ST_EMPTY;
				end else begin
					head_n         = next_slot(head_q);
					count_n        = count_q - cnt_t'(1);
					upd.take_front = 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (is_empty) begin
					upd.status = ST_EMPTY;
				end else begin
					tail_n        = prev_slot(tail_q);
					count_n       = count_q - cnt_t'(1);
					upd.take_back = 1'b1;
				end
			end
			default: begin
				if (is_empty) begin
					upd.status = ST_EMPTY;
				end
			end
		endcase
		upd.count     = count_n;
		upd.hit_front = do_write && (waddr == head_n);
		upd.hit_back  = do_write && (waddr == prev_slot(tail_n));
		upd.word      = word;
	end

	// read the new end words; a same-cycle write to either is bypassed
	assign ram_raddr_front = head_n;
	assign ram_raddr_back  = prev_slot(tail_n);
	assign ram_we          = accept && do_write;
	assign ram_waddr       = waddr;
	assign ram_wdata       = word;

	// ring pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_n;
			tail_q  <= tail_n;
			count_q <= count_n;
		end
	end
endmodule

/* design/deq_result.sv */
// result stage: combines RAM read data with the decoded update, output register
// depends on deq_pkg and deq_out_if
module deq_result (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  deq_pkg::deq_upd_t upd,
	input  deq_pkg::word_t    rd_front,
	input  deq_pkg::word_t    rd_back,
	output logic              ready,
	deq_out_if.source         rsp
);
	import deq_pkg::*;

	logic                            s1_valid_q;
	deq_upd_t                        upd_s1;
	word_t                           cur_front_q;
	word_t                           cur_back_q;
	word_t                           front_w;
	word_t                           back_w;
	word_t                           popped_w;
	logic                            advance;
	logic                            out_valid_q;
	status_t                         status_q;
	logic signed [OUT_WORD_BITS-1:0] popped_q;
	logic [COUNT_OUT_BITS-1:0]       count_q;
	logic                            empty_q;
	logic signed [OUT_WORD_BITS-1:0] front_q;
	logic signed [OUT_WORD_BITS-1:0] back_q;

	assign advance = s1_valid_q && (!out_valid_q || rsp.ready);
	assign ready   = !s1_valid_q || advance;

	// end words after the operation, with write bypass
	always_comb begin
		if (upd_s1.count == '0) begin
			front_w = '0;
			back_w  = '0;
		end else begin
			front_w = upd_s1.hit_front ? upd_s1.word : rd_front;
			back_w  = upd_s1.hit_back ? upd_s1.word : rd_back;
		end
		// a pop removes the end word left by the previous item
		if (upd_s1.take_front) begin
			popped_w = cur_front_q;
		end else if (upd_s1.take_back) begin
			popped_w = cur_back_q;
		end else begin
			popped_w = '0;
		end
	end

	// stage one occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (accept) begin
			upd_s1 <= upd;
		end
	end

	// end words seen by the next item
	always_ff @(posedge clk) begin
		if (advance) begin
			cur_front_q <= front_w;
			cur_back_q  <= back_w;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= upd_s1.status;
			popped_q <= word_to_out(popped_w);
			count_q  <= COUNT_OUT_BITS'(upd_s1.count);
			empty_q  <= (upd_s1.count == '0);
			front_q  <= word_to_out(front_w);
			back_q   <= word_to_out(back_w);
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = status_q;
	assign rsp.popped_value = popped_q;
	assign rsp.entry_count  = count_q;
	assign rsp.is_empty     = empty_q;
	assign rsp.front_value  = front_q;
	assign rsp.back_value   = back_q;
endmodule

/* design/double_ended_queue_unit.sv */
// double-ended queue of signed words in a ring RAM with head and tail pointers
// a request is held in stage one, then its result is registered in the output register
// throughput: one op per cycle unless stalled; ring RAM does one write, two reads a cycle
// a stalled response holds one item in stage one and one in the output register
// reset clears pointers, count and valid flags at once; the ring RAM is not cleared
// depends on deq_pkg, deq_in_if, deq_out_if, deq_ram, deq_ctrl, deq_result, assert_macros.svh
`include "assert_macros.svh"

module double_ended_queue_unit (
	input  logic      clk,
	input  logic      arst_n,
	deq_in_if.sink    req,
	deq_out_if.source rsp
);
	import deq_pkg::*;

	logic     accept;
	logic     s1_ready;
	logic     ram_we;
	ptr_t     ram_waddr;
	word_t    ram_wdata;
	ptr_t     ram_raddr_front;
	ptr_t     ram_raddr_back;
	word_t    rd_front;
	word_t    rd_back;
	deq_upd_t upd;

	assign req.ready = s1_ready;
	assign accept    = req.valid && s1_ready;

	// pointer and count control
	deq_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.kind            (req.kind),
		.push_value      (req.push_value),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata),
		.ram_raddr_front (ram_raddr_front),
		.ram_raddr_back  (ram_raddr_back),
		.upd             (upd)
	);

	// ring storage
	deq_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (CAPACITY)
	) u_ring (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (accept),
		.raddr_a (ram_raddr_front),
		.raddr_b (ram_raddr_back),
		.rdata_a (rd_front),
		.rdata_b (rd_back)
	);

	// result assembly and output register
	deq_result u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.upd      (upd),
		.rd_front (rd_front),
		.rd_back  (rd_back),
		.ready    (s1_ready),
		.rsp      (rsp)
	);

	// checks
	`DEQ_ASSERT(a_count_bound, clk, arst_n, accept |-> (upd.count <= FULL_COUNT))
	`DEQ_ASSERT(a_full_count, clk, arst_n, (rsp.valid && rsp.status == ST_FULL) |-> (rsp.entry_count == FULL_COUNT_OUT))
	`DEQ_ASSERT(a_stall_cause, clk, arst_n, !req.ready |-> (rsp.valid && !rsp.ready))
	`DEQ_ASSERT_NEVER(a_empty_ends, clk, arst_n, rsp.valid && rsp.is_empty && (rsp.front_value != 0 || rsp.back_value != 0))
endmodule
